/* src/tubc_pkg.sv */
// ----------------------------------------------------------------------------
// tubc_pkg: shared definitions for the timed UART bit capture unit
// Widths, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package tubc_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 48;

  localparam int unsigned PORT_VALUE_W = 8;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned LEVEL_BIT    = 5;

  localparam int unsigned BIT_PERIOD_W = 20;
  localparam int unsigned DATA_BITS_W  = 4;
  localparam int unsigned CFG_DATA_W   = BIT_PERIOD_W;
  localparam int unsigned CFG_INDEX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PORT_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BITS    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_LEVEL  = 2'd3;

  // reset values
  localparam logic                    PORT_ENABLED_RST = 1'b0;
  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST   = 20'd2671;
  localparam logic [DATA_BITS_W-1:0]  DATA_BITS_RST    = 4'd8;
  localparam logic                    START_LEVEL_RST  = 1'b1;

  localparam logic [DATA_BITS_W-1:0]  DATA_BITS_MIN    = 4'd1;
  localparam logic [DATA_BITS_W-1:0]  DATA_BITS_MAX    = 4'd8;

  // line capture phase; the spare code behaves as idle
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

endpackage

/* src/tubc_if.sv */
// ----------------------------------------------------------------------------
// tubc_wr_if / tubc_char_if: valid-ready channels of the capture unit
// Port write requests in, captured characters out.
// ----------------------------------------------------------------------------
interface tubc_wr_if import tubc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [PORT_VALUE_W-1:0] port_value;
  logic [TIME_WIDTH-1:0]   timestamp;

  modport source (output valid, output port_value, output timestamp, input ready);
  modport sink   (input valid, input port_value, input timestamp, output ready);
endinterface

interface tubc_char_if import tubc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

/* src/timed_uart_bit_capture_unit.sv */
// ----------------------------------------------------------------------------
// timed_uart_bit_capture_unit: serial character capture from timed port writes
// Rebuilds characters from the line level in bit 5 of timestamped port writes.
// ----------------------------------------------------------------------------
// Each request on port_wr is one port write with its cycle timestamp; bit 5
// is the serial line level. An idle write at start_level arms the unit, the
// first write one bit period or more later opens the data phase, and each
// later write shifts in, LSB first, one copy of the previously held level per
// whole bit period elapsed (capped at the bits still missing). When data_bits
// bits are in, the character goes out on rx_char. A write that is ignored
// (port disabled) or lands in the idle phase is done in ST_IDLE. Any other
// write passes ST_DIV, where a single subtract-and-compare unit peels one
// bit period off the elapsed time per cycle until k whole periods are found,
// capped at the bits still missing (at most 8), then ST_FIN; no new write
// is taken before it returns to ST_IDLE. A finished character sits in an
// output register, so new writes are taken while it waits; only a write that
// completes another character holds in ST_FIN until that register is free.
// Time differences wrap modulo 2^TIME_WIDTH.
module timed_uart_bit_capture_unit import tubc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tubc_wr_if.sink                port_wr,
  tubc_char_if.source            rx_char
);

  // compare width covers both the time difference and the bit period
  localparam int unsigned CMP_W = (TIME_WIDTH > BIT_PERIOD_W) ? TIME_WIDTH : BIT_PERIOD_W;

  typedef enum logic [1:0] {
    ST_IDLE,   // ready for a request
    ST_DIV,    // peel bit periods off the elapsed time
    ST_FIN     // commit state, emit character
  } seq_state_t;

  // configuration registers
  logic                    port_enabled;
  logic [BIT_PERIOD_W-1:0] bit_period;
  logic [DATA_BITS_W-1:0]  data_bits;
  logic                    start_level;

  // capture state
  phase_t                  phase;
  logic [TIME_WIDTH-1:0]   last_time;
  logic                    held_level;
  logic [CHAR_W-1:0]       shift_byte;
  logic [DATA_BITS_W-1:0]  bits_taken;

  // sequencer and working registers
  seq_state_t              st;
  logic [TIME_WIDTH-1:0]   remain;     // elapsed time left to divide
  logic [DATA_BITS_W-1:0]  count;      // whole periods found so far
  logic [DATA_BITS_W-1:0]  limit;      // stop once this many are found
  logic [DATA_BITS_W-1:0]  missing;    // bits still to take this request
  logic [DATA_BITS_W-1:0]  eff;        // clamped data_bits, latched
  logic                    level_r;
  logic [TIME_WIDTH-1:0]   now_r;

  // output register
  logic                    out_valid;
  logic [CHAR_W-1:0]       out_char;

  logic                    level_in;
  logic                    accept;
  logic                    armed;
  logic [DATA_BITS_W-1:0]  eff_in;
  logic [DATA_BITS_W-1:0]  missing_in;
  logic [CMP_W-1:0]        remain_ext;
  logic [CMP_W-1:0]        period_ext;
  logic [CMP_W-1:0]        diff;
  logic                    step_ok;
  logic                    emit;
  logic                    hold;
  logic                    load_out;

  assign level_in = port_wr.port_value[LEVEL_BIT];
  assign accept   = port_wr.valid && port_wr.ready;
  assign armed    = (phase == PH_START) || (phase == PH_DATA);

  // clamp character length to 1..8
  always_comb begin
    if (data_bits < DATA_BITS_MIN) begin
      eff_in = DATA_BITS_MIN;
    end else if (data_bits > DATA_BITS_MAX) begin
      eff_in = DATA_BITS_MAX;
    end else begin
      eff_in = data_bits;
    end
    missing_in = (eff_in > bits_taken) ? (eff_in - bits_taken) : '0;
  end

  // shared subtract / compare unit; a zero period always passes
  assign remain_ext = CMP_W'(remain);
  assign period_ext = CMP_W'(bit_period);
  assign diff       = remain_ext - period_ext;
  assign step_ok    = (count != limit) && (remain_ext >= period_ext);

  // character completes exactly at the clamped length
  assign emit     = (count != '0) && (phase == PH_DATA) && (bits_taken == eff);
  assign hold     = emit && out_valid && !rx_char.ready;
  // commit step hands a finished character to the output register
  assign load_out = (st == ST_FIN) && emit && !hold;

  assign port_wr.ready    = (st == ST_IDLE);
  assign rx_char.valid    = out_valid;
  assign rx_char.char_out = out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enabled <= PORT_ENABLED_RST;
      bit_period   <= BIT_PERIOD_RST;
      data_bits    <= DATA_BITS_RST;
      start_level  <= START_LEVEL_RST;
      phase        <= PH_IDLE;
      last_time    <= '0;
      held_level   <= ~START_LEVEL_RST;
      shift_byte   <= '0;
      bits_taken   <= '0;
      st           <= ST_IDLE;
      out_valid    <= 1'b0;
      count        <= '0;
      limit        <= '0;
      missing      <= '0;
      eff          <= DATA_BITS_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PORT_ENABLED: port_enabled <= cfg_data[0];
          REG_BIT_PERIOD:   bit_period   <= cfg_data[BIT_PERIOD_W-1:0];
          REG_DATA_BITS:    data_bits    <= cfg_data[DATA_BITS_W-1:0];
          REG_START_LEVEL:  start_level  <= cfg_data[0];
          default: ;
        endcase
      end

      // a new character may replace one taken at this same edge
      if (load_out) begin
        out_valid <= 1'b1;
        out_char  <= shift_byte;
      end else if (out_valid && rx_char.ready) begin
        out_valid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (accept && port_enabled) begin
            if (!armed) begin
              // idle (or spare code): track time, arm on start level
              last_time <= port_wr.timestamp;
              if (level_in == start_level) begin
                phase      <= PH_START;
                shift_byte <= '0;
                bits_taken <= '0;
                held_level <= level_in;
              end
            end else begin
              level_r <= level_in;
              now_r   <= port_wr.timestamp;
              remain  <= port_wr.timestamp - last_time;
              count   <= '0;
              eff     <= eff_in;
              if (phase == PH_START) begin
                limit   <= DATA_BITS_W'(1);
                missing <= '0;
              end else begin
                // at least one pass so an early write is still detected
                limit   <= (missing_in == '0) ? DATA_BITS_W'(1) : missing_in;
                missing <= missing_in;
              end
              st <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (step_ok) begin
            remain <= diff[TIME_WIDTH-1:0];
            count  <= count + DATA_BITS_W'(1);
            if ((phase == PH_DATA) && (count < missing)) begin
              shift_byte[bits_taken[2:0]] <= held_level;
              bits_taken                  <= bits_taken + DATA_BITS_W'(1);
            end
          end else begin
            st <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (count == '0) begin
            // early write: nothing changes
            st <= ST_IDLE;
          end else if (!hold) begin
            last_time  <= now_r;
            held_level <= level_r;
            if (phase == PH_START) begin
              phase <= PH_DATA;
            end else if (bits_taken >= eff) begin
              phase <= PH_IDLE;
            end
            st <= ST_IDLE;
          end
        end

        default: st <= ST_IDLE;
      endcase
    end
  end

  // periods found never pass the stop count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |-> (count <= limit))
    else $error("period count ran past its limit");

  // a character never holds more bits than the widest setting
  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    bits_taken <= DATA_BITS_MAX)
    else $error("bits_taken above maximum");

  // a new character only comes out of the commit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(st) == ST_FIN))
    else $error("character emitted outside commit");

  // while a request is in flight no other is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |=> !$past(accept))
    else $error("request accepted while dividing");

endmodule

/* dv/timed_uart_bit_capture_unit_test.sv */
// ----------------------------------------------------------------------------
// timed_uart_bit_capture_unit_test: self-checking bench for the capture unit
// Sends timestamped port write requests from a directed table and then in
// random phases, predicts each captured character in-bench, and checks every
// character that leaves on rx_char against the predicted stream.
// ----------------------------------------------------------------------------
module timed_uart_bit_capture_unit_test import tubc_pkg::*;;

  localparam int TW = TIME_WIDTH_DEF;

  // settle time before a register write: covers a write request still inside
  // the unit, plus margin for a held output character
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 1200;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tubc_wr_if #(.TIME_WIDTH(TW)) port_wr ();
  tubc_char_if                  rx_char ();

  timed_uart_bit_capture_unit #(.TIME_WIDTH(TW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .port_wr   (port_wr),
    .rx_char   (rx_char)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Character predictor: bench copy of the registers and the capture state
  // --------------------------------------------------------------------------
  logic                    cfg_enable;
  logic [BIT_PERIOD_W-1:0] cfg_period;
  logic [DATA_BITS_W-1:0]  cfg_bits;
  logic                    cfg_start;

  phase_t          cap_phase;
  logic [TW-1:0]   last_stamp;
  logic            held_level;
  logic [7:0]      shift_char;
  logic [3:0]      bits_in;

  logic [7:0] expected_chars [$];
  int         mismatch_count;
  int         items_sent;

  // Applies one write request to the predicted state; returns 1 when the
  // request completes a character, which is then placed in ch.
  function automatic bit capture_write(input logic [7:0] pv, input logic [TW-1:0] ts,
                                       output logic [7:0] ch);
    logic              lvl;
    logic              bit_in;
    logic [TW-1:0]     elapsed;
    longint unsigned   periods;
    longint unsigned   eff;
    longint unsigned   missing;
    longint unsigned   take;
    ch = '0;
    if (!cfg_enable) return 1'b0;   // disabled port: nothing moves
    lvl = pv[LEVEL_BIT];
    elapsed = ts - last_stamp;      // wraps modulo 2^TW
    // zero period counts as "plenty of periods"
    periods = (cfg_period == '0) ? {64{1'b1}} : elapsed / cfg_period;

    if (cap_phase != PH_START && cap_phase != PH_DATA) begin
      // idle: stamp always taken, arm only on the start level
      last_stamp = ts;
      if (lvl == cfg_start) begin
        cap_phase  = PH_START;
        shift_char = '0;
        bits_in    = '0;
        held_level = lvl;
      end
      return 1'b0;
    end

    // early write: less than one period since the last one, fully ignored
    if (periods == 0) return 1'b0;

    last_stamp = ts;
    if (cap_phase == PH_START) begin
      cap_phase  = PH_DATA;
      held_level = lvl;
      return 1'b0;
    end

    bit_in     = held_level;
    held_level = lvl;
    eff = (cfg_bits == 0) ? 1 : (cfg_bits > 8) ? 8 : cfg_bits;
    missing = (eff > bits_in) ? eff - bits_in : 0;
    take = (periods < missing) ? periods : missing;
    for (longint unsigned n = 0; n < take; n++) begin
      if (bit_in) shift_char[bits_in[2:0]] = 1'b1;
      bits_in++;
    end

    // back to idle when full; data bits lowered below bits in: no output
    if (bits_in >= eff) begin
      cap_phase = PH_IDLE;
      if (bits_in == eff) begin
        ch = shift_char;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {
    CHAR_BY_MODEL,   // predictor decides
    CHAR_NONE,       // known to produce nothing
    CHAR_GIVEN       // known character, typed in the table
  } char_check_t;

  bit steady_phase;  // no sender gaps for this phase

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Predicts, queues the expectation, then holds the request until accepted.
  // valid is left high on return; the next call or settle_unit decides.
  task automatic send_write(input logic [7:0] pv, input logic [TW-1:0] ts,
                            input char_check_t check, input logic [7:0] given);
    logic [7:0] predicted;
    bit         has_char;
    int         gap;
    has_char = capture_write(pv, ts, predicted);
    case (check)
      CHAR_BY_MODEL: if (has_char) expected_chars.push_back(predicted);
      CHAR_GIVEN:    expected_chars.push_back(given);
      default: ;
    endcase
    if (cfg_enable) items_sent++;

    gap = pick_gap();
    if (gap > 0) begin
      port_wr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    port_wr.valid      <= 1'b1;
    port_wr.port_value <= pv;
    port_wr.timestamp  <= ts;
    @(posedge clk);
    while (!port_wr.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted character, then let any write that
  // produces no character run out inside the unit.
  task automatic settle_unit();
    port_wr.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; cfg_we is left high so back-to-back writes need no
  // lowering in between. The caller drops it after the batch.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PORT_ENABLED: cfg_enable = val[0];
      REG_BIT_PERIOD:   cfg_period = val[BIT_PERIOD_W-1:0];
      REG_DATA_BITS:    cfg_bits   = val[DATA_BITS_W-1:0];
      REG_START_LEVEL:  cfg_start  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef enum logic {ROW_WRITE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [7:0]             pv;
    logic [TW-1:0]          ts;
    char_check_t            check;
    logic [7:0]             ch;
  } stim_row_t;

  localparam int NUM_ROWS = 39;

  // Line level is bit 5: 8'h20/8'hFF are level 1, 8'h00/8'hDF are level 0.
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // port still disabled after reset: request swallowed
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hFF, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_PORT_ENABLED, 20'd1, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_BIT_PERIOD, 20'd4, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    // full 8-bit character 0xA5, one and two period steps
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd100, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hFF, 48'd104, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd108, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd112, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hDF, 48'd116, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hFF, 48'd124, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd128, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd132, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd136, CHAR_BY_MODEL, 8'h00},
    // idle write off the start level, arm, early write, then saturation
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd200, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd201, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd203, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hFF, 48'd205, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd245, CHAR_GIVEN, 8'hFF},
    // data bits zero acts as one, start level low
    '{ROW_REG, REG_DATA_BITS, 20'd0, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_START_LEVEL, 20'd0, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd300, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd304, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd308, CHAR_GIVEN, 8'h01},
    // data bits above eight act as eight; zero period fills at once
    '{ROW_REG, REG_DATA_BITS, 20'd15, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_BIT_PERIOD, 20'd0, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hDF, 48'd400, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd400, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd400, CHAR_GIVEN, 8'hFF},
    // widest period across the timestamp wrap, two data bits
    '{ROW_REG, REG_BIT_PERIOD, 20'hFFFFF, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_DATA_BITS, 20'd2, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'hFFFF_FFFF_FFF6, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'hFF, 48'd1048565, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd3145715, CHAR_GIVEN, 8'h03},
    // data bits lowered under the bits already taken: dropped character
    '{ROW_REG, REG_BIT_PERIOD, 20'd4, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_REG, REG_DATA_BITS, 20'd8, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd500, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h20, 48'd504, CHAR_BY_MODEL, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd516, CHAR_BY_MODEL, 8'h00},
    '{ROW_REG, REG_DATA_BITS, 20'd2, 8'h00, 48'd0, CHAR_NONE, 8'h00},
    '{ROW_WRITE, REG_PORT_ENABLED, 20'd0, 8'h00, 48'd520, CHAR_BY_MODEL, 8'h00}
  };

  // --------------------------------------------------------------------------
  // Random requests
  // --------------------------------------------------------------------------
  logic [TW-1:0] line_clock;   // running timestamp of the emulated CPU

  // Mostly well-formed frames: arm at the start level, then steps of whole
  // bit periods plus a fraction. The rest is noise: any level, odd steps,
  // early writes, and stamps jumping anywhere in the 48-bit range.
  task automatic random_write();
    int            pick;
    int            k;
    logic [63:0]   wide;
    logic [TW-1:0] step;
    logic [7:0]    pv;
    pick = $urandom_range(0, 99);
    wide = {$urandom(), $urandom()};
    pv   = 8'($urandom_range(0, 255));
    if (pick < 4) begin
      line_clock = wide[TW-1:0];
    end else if (pick < 10) begin
      line_clock = line_clock + TW'($urandom_range(0, 64));
    end else begin
      if (cap_phase == PH_IDLE) begin
        pv[LEVEL_BIT] = ($urandom_range(0, 99) < 85) ? cfg_start : !cfg_start;
        step = TW'($urandom_range(0, 40));
      end else begin
        // k = 0 lands inside the current bit: an early write
        k = (pick < 18) ? 0 : (pick < 28) ? $urandom_range(3, 10) : $urandom_range(1, 2);
        if (cfg_period == '0) step = TW'($urandom_range(0, 20));
        else step = TW'(k * cfg_period + $urandom_range(0, cfg_period - 1));
      end
      line_clock = line_clock + step;
    end
    send_write(pv, line_clock, CHAR_BY_MODEL, 8'h00);
  endtask

  // New register settings for a phase; extremes show up often. Narrow
  // registers get junk in the unused upper data bits.
  task automatic random_settings();
    int                    r;
    logic [CFG_DATA_W-1:0] val;
    settle_unit();
    val = CFG_DATA_W'($urandom());
    val[0] = ($urandom_range(0, 99) < 90);
    program_reg(REG_PORT_ENABLED, val);

    r = $urandom_range(0, 99);
    if (r < 8)       val = '0;
    else if (r < 16) val = 20'hFFFFF;
    else if (r < 24) val = 20'd1;
    else if (r < 34) val = CFG_DATA_W'($urandom_range(2, 20'hFFFFF));
    else             val = CFG_DATA_W'($urandom_range(2, 12));
    program_reg(REG_BIT_PERIOD, val);

    val = CFG_DATA_W'($urandom());
    val[DATA_BITS_W-1:0] = DATA_BITS_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                         : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15)));
    program_reg(REG_DATA_BITS, val);

    val = CFG_DATA_W'($urandom());
    program_reg(REG_START_LEVEL, val);
    cfg_we <= 1'b0;

    steady_phase = ($urandom_range(0, 99) < 20);
    // now and then park the clock just under the wrap point
    if ($urandom_range(0, 9) == 0) line_clock = '1 - TW'($urandom_range(0, 200));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready in runs, short and long stalls, long open stretches
  // --------------------------------------------------------------------------
  int ready_hold;
  int ready_pick;

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 35) begin
        rx_char.ready <= 1'b1;
        ready_hold    <= $urandom_range(1, 6);
      end else if (ready_pick < 55) begin
        rx_char.ready <= 1'b1;
        ready_hold    <= $urandom_range(20, 80);
      end else if (ready_pick < 90) begin
        rx_char.ready <= 1'b0;
        ready_hold    <= $urandom_range(0, 3);
      end else begin
        rx_char.ready <= 1'b0;
        ready_hold    <= $urandom_range(15, 40);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Character checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  logic [7:0] want_char;

  always @(posedge clk) begin
    if (!rst && rx_char.valid && rx_char.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("char_out %02h with no character pending",
                                  rx_char.char_out));
      end else begin
        want_char = expected_chars.pop_front();
        if (rx_char.char_out !== want_char)
          report_mismatch($sformatf("char_out %02h, predicted %02h",
                                    rx_char.char_out, want_char));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    bit        wrote_since_reg;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    port_wr.valid      = 1'b0;
    port_wr.port_value = '0;
    port_wr.timestamp  = '0;
    rx_char.ready      = 1'b0;
    ready_hold         = 0;
    mismatch_count     = 0;
    items_sent         = 0;
    steady_phase       = 1'b0;
    wrote_since_reg    = 1'b0;

    // predictor starts from the unit's reset state
    cfg_enable = PORT_ENABLED_RST;
    cfg_period = BIT_PERIOD_RST;
    cfg_bits   = DATA_BITS_RST;
    cfg_start  = START_LEVEL_RST;
    cap_phase  = PH_IDLE;
    last_stamp = '0;
    held_level = !START_LEVEL_RST;
    shift_char = '0;
    bits_in    = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; registers only change once the unit has drained
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        if (wrote_since_reg) settle_unit();
        wrote_since_reg = 1'b0;
        program_reg(row.idx, row.val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        wrote_since_reg = 1'b1;
        send_write(row.pv, row.ts, row.check, row.ch);
      end
    end
    line_clock = DIRECTED_ROWS[NUM_ROWS-1].ts;

    // random phases; a phase may end mid-character, so the next settings
    // also hit a partly built character
    while (items_sent < RANDOM_ITEMS) begin
      random_settings();
      repeat ($urandom_range(15, 60)) random_write();
    end

    settle_unit();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
